>>> src/halt_pkg.sv
// ----------------------------------------------------------------------------
// halt_pkg
// Types and constants shared by the Halton point generator and its cells.
// ----------------------------------------------------------------------------
package halt_pkg;

    localparam int COORD_W     = 32;
    localparam int NUM_BASES   = 8;
    // Wide enough for base^digits of any 32-bit index and for the doubled
    // remainder of the final long division.
    localparam int DEN_W       = 37;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 36;
    localparam int CNT_W       = 5;

    localparam logic [4:0] PRIME [NUM_BASES] = '{
        5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19
    };

    // floor(2^36 / prime): the quotient estimate is low by at most one.
    localparam logic [RECIP_W-1:0] RECIP [NUM_BASES] = '{
        36'((64'd1 << RECIP_SHIFT) / 64'd2),
        36'((64'd1 << RECIP_SHIFT) / 64'd3),
        36'((64'd1 << RECIP_SHIFT) / 64'd5),
        36'((64'd1 << RECIP_SHIFT) / 64'd7),
        36'((64'd1 << RECIP_SHIFT) / 64'd11),
        36'((64'd1 << RECIP_SHIFT) / 64'd13),
        36'((64'd1 << RECIP_SHIFT) / 64'd17),
        36'((64'd1 << RECIP_SHIFT) / 64'd19)
    };

    typedef struct packed {
        logic start;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> src/halt_cell.sv
// ----------------------------------------------------------------------------
// halt_cell
// One radical-inverse cell for a fixed prime base, with a coordinate register
// that shifts toward the head of the chain.
// ----------------------------------------------------------------------------
module halt_cell #(
    parameter int CELL  = 0,
    parameter int IDX_W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  halt_pkg::t_cell_ctrl          i_ctrl,
    input  logic [IDX_W-1:0]              i_index,
    input  logic [halt_pkg::COORD_W-1:0]  i_next_coord,
    output logic [halt_pkg::COORD_W-1:0]  o_coord,
    output logic                          o_done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FIX  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam logic [4:0]                   BASE = halt_pkg::PRIME[CELL];
    localparam logic [halt_pkg::RECIP_W-1:0] MAG  = halt_pkg::RECIP[CELL];
    localparam int PROD_W = IDX_W + halt_pkg::RECIP_W;

    logic [2:0]                     r_state, n_state;
    logic [IDX_W-1:0]               r_x, n_x;
    logic [IDX_W-1:0]               r_q, n_q;
    logic [halt_pkg::DEN_W-1:0]     r_rev, n_rev;
    logic [halt_pkg::DEN_W-1:0]     r_den, n_den;
    logic [halt_pkg::COORD_W-1:0]   r_coord, n_coord;
    logic [halt_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    logic [PROD_W-1:0]              w_prod;
    logic [IDX_W+4:0]               w_qb;
    logic [IDX_W+4:0]               w_rem;
    logic                           w_over;
    logic [4:0]                     w_dig;
    logic [IDX_W-1:0]               w_qc;
    logic [halt_pkg::DEN_W:0]       w_rsh;
    logic                           w_ge;

    assign w_prod = PROD_W'(r_x) * PROD_W'(MAG);
    assign w_qb   = (IDX_W+5)'(r_q) * (IDX_W+5)'(BASE);
    assign w_rem  = (IDX_W+5)'(r_x) - w_qb;
    assign w_over = (w_rem >= (IDX_W+5)'(BASE));
    assign w_dig  = w_over ? 5'(w_rem - (IDX_W+5)'(BASE)) : 5'(w_rem);
    assign w_qc   = r_q + IDX_W'(w_over);
    assign w_rsh  = {r_rev, 1'b0};
    assign w_ge   = (w_rsh >= {1'b0, r_den});

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_q     = r_q;
        n_rev   = r_rev;
        n_den   = r_den;
        n_coord = r_coord;
        n_cnt   = r_cnt;
        case (r_state)
            ST_MUL: begin
                n_q     = w_prod[PROD_W-1:halt_pkg::RECIP_SHIFT] == '0 ? '0 :
                          IDX_W'(w_prod >> halt_pkg::RECIP_SHIFT);
                n_state = ST_FIX;
            end
            ST_FIX: begin
                n_x   = w_qc;
                n_rev = halt_pkg::DEN_W'(r_rev * halt_pkg::DEN_W'(BASE))
                        + halt_pkg::DEN_W'(w_dig);
                n_den = halt_pkg::DEN_W'(r_den * halt_pkg::DEN_W'(BASE));
                if (w_qc == '0) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DIV: begin
                // One quotient bit of rev * 2^32 / den each cycle.
                n_rev   = w_ge ? halt_pkg::DEN_W'(w_rsh - {1'b0, r_den})
                               : halt_pkg::DEN_W'(w_rsh);
                n_coord = {r_coord[halt_pkg::COORD_W-2:0], w_ge};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == halt_pkg::CNT_W'(halt_pkg::COORD_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ctrl.shift) begin
                    n_coord = i_next_coord;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_ctrl.start) begin
            n_x     = i_index;
            n_rev   = '0;
            n_den   = halt_pkg::DEN_W'(1);
            n_coord = '0;
            n_cnt   = '0;
            n_state = (i_index == '0) ? ST_DIV : ST_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x     <= n_x;
        r_q     <= n_q;
        r_rev   <= n_rev;
        r_den   <= n_den;
        r_coord <= n_coord;
        r_cnt   <= n_cnt;
    end

    assign o_coord = r_coord;
    assign o_done  = (r_state == ST_DONE);

endmodule

>>> src/halton_point_generator.sv
// ----------------------------------------------------------------------------
// halton_point_generator
// Emits Halton point coordinates in bases 2..19 for each sample index.
// ----------------------------------------------------------------------------
// Latency grows with the digits of the index: each cell runs a multiply
// and a fix-up state per digit, then the long division; the base-2 cell, with
// the most digits, sets it. A new index is taken once the last result of
// the prior index is registered; results leave one per cycle unless stalled.
// Reset is synchronous, active low; it idles the control and sets
// dimensions to 3.
module halton_point_generator #(
    parameter int MAX_DIMS   = 8,
    parameter int INDEX_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: sample_index[31:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // Output stream. tdata: coordinate[31:0]. tuser: dim_number[2:0].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic       REG_DIMS = 1'b0;

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_dims;
    logic [3:0]  r_n, n_n;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_vld, n_vld;
    logic [31:0] r_data, n_data;
    logic [2:0]  r_user, n_user;
    logic        r_last, n_last;

    halt_pkg::t_cell_ctrl                w_ctrl;
    logic [halt_pkg::COORD_W-1:0]        w_coord [MAX_DIMS+1];
    logic [MAX_DIMS-1:0]                 w_done;
    logic [3:0]                          w_neff;
    logic                                w_in_xfer;
    logic                                w_load;
    logic                                w_is_last;

    // Write happens on the access cycle; pready is tied high.
    assign pready = 1'b1;
    assign prdata = {28'd0, r_dims};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 4'd3;
        end else if (psel && penable && pwrite && paddr[2] == REG_DIMS) begin
            r_dims <= pwdata[3:0];
        end
    end

    // Zero dimensions act as one; anything past the cell count saturates.
    always_comb begin
        if (r_dims == 4'd0) begin
            w_neff = 4'd1;
        end else if (r_dims > 4'(MAX_DIMS)) begin
            w_neff = 4'(MAX_DIMS);
        end else begin
            w_neff = r_dims;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    // In the emit state the head of the chain moves into the output register
    // when that register is empty or its transfer completes in this cycle.
    assign w_load        = (r_state == ST_EMIT) && (!r_vld || m_axis_tready);
    assign w_is_last     = ({1'b0, r_cnt} + 4'd1 == r_n);

    assign w_ctrl.start = w_in_xfer;
    assign w_ctrl.shift = w_load;

    // Every cell works on the same index in its own base, all in parallel.
    assign w_coord[MAX_DIMS] = '0;
    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
        halt_cell #(
            .CELL  (g),
            .IDX_W (INDEX_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_index      (s_axis_tdata[INDEX_BITS-1:0]),
            .i_next_coord (w_coord[g+1]),
            .o_coord      (w_coord[g]),
            .o_done       (w_done[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_cnt   = r_cnt;
        n_vld   = r_vld;
        n_data  = r_data;
        n_user  = r_user;
        n_last  = r_last;
        if (r_vld && m_axis_tready) begin
            n_vld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_CALC;
                    n_n     = w_neff;
                    n_cnt   = '0;
                end
            end
            ST_CALC: begin
                if (&w_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_vld  = 1'b1;
                    n_data = w_coord[0];
                    n_user = r_cnt;
                    n_last = w_is_last;
                    n_cnt  = r_cnt + 1'b1;
                    if (w_is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
        end
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_user;
    assign m_axis_tlast  = r_last;

endmodule

>>> src/halt_checker.sv
// ----------------------------------------------------------------------------
// halt_checker
// Port-level checks for the Halton point generator, bound to the top level.
// ----------------------------------------------------------------------------
module halt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Only one index is in flight at a time.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second index accepted while busy");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A result that is not the last is followed by the next dimension.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tvalid
        |=> !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser) + 3'd1)
        else $error("dimension order broken");

endmodule

bind halton_point_generator halt_checker u_halt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
